### hdl/mmdec_pkg.sv
`default_nettype none

package mmdec_pkg;

  // default sizes
  localparam int DEF_MAX_COLUMNS  = 1024;
  localparam int DEF_SAMPLE_WIDTH = 16;

  // register and field widths fixed by the register map
  localparam int ILEN_W       = 16;
  localparam int OLEN_FIELD_W = 11;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int STEP_W       = 7;
  localparam int ACC_W        = 8;
  localparam int PCT_FULL     = 100;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LENGTH = 1'b1;

  // sequencer for the group size / percent step division
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_BASE,
    DIV_PCT
  } div_state_t;

endpackage

`default_nettype wire

### hdl/minmax_decimator_unit.sv
// min/max decimator: the result beat of an accepted sample beat is registered into the output
// register, or into the skid entry while the output waits; throughput one sample per cycle while
// in_stall is low; a two-deep output buffer lets input continue while a result waits; after a
// register write the group size and percent step are derived by a shared one-bit-per-cycle
// divider of DW bits (DW = max(16, clog2(MAX_COLUMNS+1)+7)); while it runs, in_stall is high
// synchronous active-high reset clears both lengths, so samples are taken and dropped
`default_nettype none

module minmax_decimator_unit #(
  parameter int MAX_COLUMNS  = mmdec_pkg::DEF_MAX_COLUMNS,
  parameter int SAMPLE_WIDTH = mmdec_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_write,
  input  wire  [mmdec_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [mmdec_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  signed [SAMPLE_WIDTH-1:0]       sample,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]       max_value,
  output logic signed [SAMPLE_WIDTH-1:0]       min_value,
  output logic                                 last_group
);
  import mmdec_pkg::*;

  localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
  localparam int LEFT_W = ILEN_W + 1;
  localparam int PROD_W = COL_W + 7;
  localparam int DW     = (ILEN_W > PROD_W) ? ILEN_W : PROD_W;
  localparam int CNT_W  = $clog2(DW + 1);

  // configuration and derived values
  logic [ILEN_W-1:0] ilen;
  logic [COL_W-1:0]  olen;
  logic [ILEN_W-1:0] base;
  logic [STEP_W-1:0] step;

  // divider
  div_state_t       state, state_next;
  logic [DW-1:0]    dvd;
  logic [DW-1:0]    quo;
  logic [COL_W:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic [COL_W:0]   rem_sh;
  logic             q_bit;
  logic [COL_W:0]   rem_step;
  logic [PROD_W-1:0] pct_dvd;
  logic             busy;
  logic             div_done;

  // frame state
  logic [ACC_W-1:0]  acc;
  logic [LEFT_W-1:0] grp_left;
  logic signed [SAMPLE_WIDTH-1:0] run_max, run_min;
  logic [COL_W-1:0]  groups;
  logic [ILEN_W-1:0] consumed;

  logic [ACC_W-1:0]  acc_sum, acc_adj, acc_next;
  logic              pct_carry;
  logic [LEFT_W-1:0] grp_size, left_dec, grp_left_next;
  logic signed [SAMPLE_WIDTH-1:0] max_next, min_next;
  logic [COL_W-1:0]  groups_next;
  logic [ILEN_W-1:0] consumed_next;
  logic [ILEN_W:0]   cons_inc;
  logic              frame_end, in_group, hit, last_next, enabled;

  // output buffer
  logic              skid_valid;
  logic signed [SAMPLE_WIDTH-1:0] skid_max, skid_min;
  logic              skid_last;
  logic              in_acc, take, produce;

  assign busy     = (state != DIV_IDLE);
  assign in_stall = busy || skid_valid;
  assign in_acc   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;
  assign enabled  = (ilen != '0) && (olen != '0);
  assign produce  = in_acc && enabled && hit;

  // restoring division, one quotient bit per cycle
  assign rem_sh   = {rem[COL_W-1:0], dvd[DW-1]};
  assign q_bit    = (rem_sh >= {1'b0, olen});
  assign rem_step = q_bit ? (rem_sh - {1'b0, olen}) : rem_sh;
  assign pct_dvd  = {7'd0, rem[COL_W-1:0]} * PROD_W'(PCT_FULL);
  assign div_done = (cnt == CNT_W'(DW));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: state_next = DIV_IDLE;
      DIV_LOAD: state_next = (olen == '0) ? DIV_IDLE : DIV_BASE;
      DIV_BASE: if (div_done) state_next = DIV_PCT;
      DIV_PCT:  if (div_done) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
    // any register write restarts the derivation
    if (cfg_write) state_next = DIV_LOAD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ilen <= '0;
      olen <= '0;
      base <= '0;
      step <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_INPUT_LENGTH: ilen <= cfg_data[ILEN_W-1:0];
          REG_OUTPUT_LENGTH: begin
            if (32'(cfg_data[OLEN_FIELD_W-1:0]) > 32'(MAX_COLUMNS)) begin
              olen <= COL_W'(MAX_COLUMNS);
            end else begin
              olen <= COL_W'(cfg_data[OLEN_FIELD_W-1:0]);
            end
          end
          default: ;
        endcase
      end else begin
        case (state)
          DIV_LOAD: begin
            if (olen == '0) begin
              base <= '0;
              step <= '0;
            end
          end
          DIV_BASE: if (div_done) base <= quo[ILEN_W-1:0];
          DIV_PCT:  if (div_done) step <= quo[STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == DIV_LOAD || (state == DIV_BASE && div_done)) begin
      dvd <= (state == DIV_LOAD) ? DW'(ilen) : DW'(pct_dvd);
      quo <= '0;
      rem <= '0;
      cnt <= '0;
    end else if (busy && !div_done) begin
      dvd <= {dvd[DW-2:0], 1'b0};
      quo <= {quo[DW-2:0], q_bit};
      rem <= rem_step;
      cnt <= cnt + 1'b1;
    end
  end

  // per-sample group tracking
  always_comb begin
    acc_sum   = acc + ACC_W'(step);
    pct_carry = (acc_sum >= ACC_W'(PCT_FULL));
    acc_adj   = pct_carry ? (acc_sum - ACC_W'(PCT_FULL)) : acc_sum;
    grp_size  = {1'b0, base} + LEFT_W'(pct_carry);
    // an empty group still takes one sample
    if (grp_size == '0) grp_size = LEFT_W'(1);
    cons_inc  = {1'b0, consumed} + 1'b1;
    frame_end = (cons_inc >= {1'b0, ilen});

    acc_next      = acc;
    grp_left_next = grp_left;
    max_next      = run_max;
    min_next      = run_min;
    groups_next   = groups;
    consumed_next = cons_inc[ILEN_W-1:0];
    in_group      = 1'b0;
    hit           = 1'b0;

    if (grp_left == '0) begin
      if (groups < olen) begin
        acc_next      = acc_adj;
        grp_left_next = grp_size;
        max_next      = sample;
        min_next      = sample;
        in_group      = 1'b1;
      end
    end else begin
      if (sample > run_max) max_next = sample;
      if (sample < run_min) min_next = sample;
      in_group = 1'b1;
    end

    left_dec  = grp_left_next - 1'b1;
    last_next = (({1'b0, groups} + 1'b1) >= {1'b0, olen}) || frame_end;

    if (in_group) begin
      grp_left_next = left_dec;
      if (left_dec == '0 || frame_end) begin
        grp_left_next = '0;
        groups_next   = groups + 1'b1;
        hit           = 1'b1;
      end
    end

    if (frame_end) begin
      acc_next      = '0;
      grp_left_next = '0;
      groups_next   = '0;
      consumed_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      acc      <= '0;
      grp_left <= '0;
      groups   <= '0;
      consumed <= '0;
    end else if (in_acc && enabled) begin
      acc      <= acc_next;
      grp_left <= grp_left_next;
      groups   <= groups_next;
      consumed <= consumed_next;
    end
    if (rst || cfg_write) begin
      run_max <= '0;
      run_min <= '0;
    end else if (in_acc && enabled) begin
      run_max <= max_next;
      run_min <= min_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (produce) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        max_value  <= skid_max;
        min_value  <= skid_min;
        last_group <= skid_last;
      end
    end else if (produce) begin
      if (!out_valid || take) begin
        max_value  <= max_next;
        min_value  <= min_next;
        last_group <= last_next;
      end else begin
        skid_max  <= max_next;
        skid_min  <= min_next;
        skid_last <= last_next;
      end
    end
  end

endmodule

`default_nettype wire

### verif/minmax_decimator_checker.sv
module minmax_decimator_checker #(
  parameter int MAX_COLUMNS  = mmdec_pkg::DEF_MAX_COLUMNS,
  parameter int SAMPLE_WIDTH = mmdec_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_write,
  input  wire [mmdec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [mmdec_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                               in_valid,
  input  wire                               in_stall,
  input  wire signed [SAMPLE_WIDTH-1:0]     sample,
  input  wire                               out_valid,
  input  wire                               out_stall,
  input  wire signed [SAMPLE_WIDTH-1:0]     max_value,
  input  wire signed [SAMPLE_WIDTH-1:0]     min_value,
  input  wire                               last_group,
  output int                                fail_count,
  output int                                pending,
  output int                                columns_checked
);
  import mmdec_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] col_max;
    logic signed [SAMPLE_WIDTH-1:0] col_min;
    logic                           col_last;
  } column_t;

  column_t expected_cols[$];

  logic [ILEN_W-1:0]              frame_len;
  logic [OLEN_FIELD_W-1:0]        column_count;
  logic [ILEN_W-1:0]              base_size;
  logic [STEP_W-1:0]              pct_step;
  logic [ACC_W-1:0]               pct_acc;
  logic [ILEN_W:0]                left_in_col;
  logic signed [SAMPLE_WIDTH-1:0] run_max;
  logic signed [SAMPLE_WIDTH-1:0] run_min;
  logic [OLEN_FIELD_W-1:0]        cols_done;
  logic [ILEN_W-1:0]              taken;
  int                             mismatches = 0;
  int                             checked_n = 0;

  function automatic void start_new_frame();
    pct_acc     = '0;
    left_in_col = '0;
    cols_done   = '0;
    taken       = '0;
  endfunction

  function automatic void clear_state();
    frame_len    = '0;
    column_count = '0;
    base_size    = '0;
    pct_step     = '0;
    run_max      = '0;
    run_min      = '0;
    start_new_frame();
    expected_cols.delete();
  endfunction

  function automatic void program_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
    int cols;
    if (idx == REG_INPUT_LENGTH) begin
      frame_len = data[ILEN_W-1:0];
    end else begin
      // only the low field bits count, and the column count saturates
      cols = int'(data[OLEN_FIELD_W-1:0]);
      column_count = OLEN_FIELD_W'((cols > MAX_COLUMNS) ? MAX_COLUMNS : cols);
    end
    if (column_count == 0) begin
      base_size = '0;
      pct_step  = '0;
    end else begin
      base_size = frame_len / column_count;
      pct_step  = STEP_W'(((int'(frame_len) % int'(column_count)) * PCT_FULL)
                          / int'(column_count));
    end
    start_new_frame();
  endfunction

  function automatic void take_sample(logic signed [SAMPLE_WIDTH-1:0] s);
    logic    in_col;
    logic    frame_end;
    int      col_size;
    column_t col;
    if (frame_len == 0 || column_count == 0) return;
    in_col = 1'b0;
    if (left_in_col == 0) begin
      // beats past the last column are swallowed until the frame ends
      if (cols_done < column_count) begin
        col_size = int'(base_size);
        pct_acc  = pct_acc + pct_step;
        if (pct_acc >= PCT_FULL) begin
          col_size++;
          pct_acc = pct_acc - ACC_W'(PCT_FULL);
        end
        if (col_size == 0) col_size = 1;
        left_in_col = (ILEN_W+1)'(col_size);
        run_max     = s;
        run_min     = s;
        in_col      = 1'b1;
      end
    end else begin
      if (s > run_max) run_max = s;
      if (s < run_min) run_min = s;
      in_col = 1'b1;
    end
    taken     = taken + 1'b1;
    frame_end = (taken >= frame_len);
    if (in_col) begin
      left_in_col = left_in_col - 1'b1;
      // a column cut short by the frame end goes out at once
      if (left_in_col == 0 || frame_end) begin
        left_in_col  = '0;
        cols_done    = cols_done + 1'b1;
        col.col_max  = run_max;
        col.col_min  = run_min;
        col.col_last = (cols_done >= column_count) || frame_end;
        expected_cols.push_back(col);
      end
    end
    if (frame_end) start_new_frame();
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("column check: %s", msg);
  endtask

  task automatic check_column();
    column_t want;
    if (expected_cols.size() == 0) begin
      report_mismatch($sformatf("beat max %0d min %0d last %0b with nothing expected",
                                max_value, min_value, last_group));
    end else begin
      want = expected_cols.pop_front();
      checked_n++;
      if (max_value !== want.col_max)
        report_mismatch($sformatf("column %0d max_value %0d, want %0d",
                                  checked_n, max_value, want.col_max));
      if (min_value !== want.col_min)
        report_mismatch($sformatf("column %0d min_value %0d, want %0d",
                                  checked_n, min_value, want.col_min));
      if (last_group !== want.col_last)
        report_mismatch($sformatf("column %0d last_group %0b, want %0b",
                                  checked_n, last_group, want.col_last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (cfg_write) program_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) take_sample(sample);
      if (out_valid && !out_stall) check_column();
    end
    fail_count      <= mismatches;
    pending         <= expected_cols.size();
    columns_checked <= checked_n;
  end

endmodule

### verif/tb_minmax_decimator_unit.sv
module tb_minmax_decimator_unit;
  import mmdec_pkg::*;

  localparam int SW          = DEF_SAMPLE_WIDTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_BEATS  = 1450;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_INPUT_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic signed [SW-1:0]  sample    = '0;
  logic                  out_stall = 1'b0;
  wire                   in_stall;
  wire                   out_valid;
  wire signed [SW-1:0]   max_value;
  wire signed [SW-1:0]   min_value;
  wire                   last_group;

  int fail_count;
  int pending;
  int columns_checked;
  int cycles        = 0;
  int beats_sent    = 0;
  int settings_used = 0;
  int send_gap_pct  = 7;
  int stall_pct     = 72;

  minmax_decimator_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .max_value  (max_value),
    .min_value  (min_value),
    .last_group (last_group)
  );

  minmax_decimator_checker column_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .sample          (sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .max_value       (max_value),
    .min_value       (min_value),
    .last_group      (last_group),
    .fail_count      (fail_count),
    .pending         (pending),
    .columns_checked (columns_checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_minmax_decimator_unit NOT OK");
      $finish;
    end
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    // let the divider start, then wait for it to release the input
    repeat (2) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic push_sample(input logic signed [SW-1:0] value);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // beats that close no column may still be in flight
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(SW-1){1'b1}}};
      1:       return {1'b1, {(SW-1){1'b0}}};
      2:       return SW'(int'($urandom_range(0, 6)) - 3);
      default: return SW'($urandom());
    endcase
  endfunction

  initial begin
    logic signed [SW-1:0] corner[7] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                        16'h0001, 16'h5555, 16'hAAAA};
    int counted;
    int pick;
    int frame;
    int cols;
    int olen_data;
    int n_beats;

    counted = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // both lengths zero after reset: beats are swallowed
    push_sample(corner[0]);
    push_sample(corner[1]);
    settle();
    set_reg(REG_INPUT_LENGTH, 7);
    push_sample(pick_sample());
    settle();
    // 7 into 3: three columns of two, then one surplus beat
    set_reg(REG_OUTPUT_LENGTH, 3);
    foreach (corner[i]) push_sample(corner[i]);
    settle();
    // fewer beats than columns: the frame ends early
    set_reg(REG_INPUT_LENGTH, 3);
    set_reg(REG_OUTPUT_LENGTH, 5);
    repeat (3) push_sample(pick_sample());
    settle();
    // widest frame, column count saturated through the masked field
    set_reg(REG_INPUT_LENGTH, 16'hFFFF);
    set_reg(REG_OUTPUT_LENGTH, 16'hFFFF);
    repeat (4) push_sample(pick_sample());
    settle();
    set_reg(REG_INPUT_LENGTH, 0);
    set_reg(REG_OUTPUT_LENGTH, 1);
    push_sample(pick_sample());
    settle();
    set_reg(REG_INPUT_LENGTH, 1);
    push_sample(corner[3]);
    push_sample(corner[4]);
    settle();
    settings_used = 7;

    while (counted < RAND_BEATS) begin
      if (counted < RAND_BEATS / 3) begin
        send_gap_pct = 7;
        stall_pct    = 72;
      end else if (counted < 2 * RAND_BEATS / 3) begin
        send_gap_pct = 72;
        stall_pct    = 7;
      end else begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        frame   = $urandom_range(1000, 65535);
        cols    = ($urandom_range(0, 3) == 0) ? $urandom_range(1025, 2047)
                                              : $urandom_range(1, 1024);
        n_beats = $urandom_range(100, 250);
      end else if (pick < 10) begin
        frame   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
        cols    = (frame == 0) ? $urandom_range(1, 40) : 0;
        n_beats = 3;
      end else begin
        frame   = $urandom_range(1, 48);
        cols    = $urandom_range(1, 60);
        n_beats = $urandom_range(1, 3) * frame + $urandom_range(0, frame);
      end
      // junk above the column field must be ignored
      olen_data = cols;
      if ($urandom_range(0, 3) == 0) olen_data = cols | ($urandom_range(0, 31) << OLEN_FIELD_W);
      if ($urandom_range(0, 1)) begin
        set_reg(REG_INPUT_LENGTH, CFG_DATA_W'(frame));
        set_reg(REG_OUTPUT_LENGTH, CFG_DATA_W'(olen_data));
      end else begin
        set_reg(REG_OUTPUT_LENGTH, CFG_DATA_W'(olen_data));
        set_reg(REG_INPUT_LENGTH, CFG_DATA_W'(frame));
      end
      repeat (n_beats) push_sample(pick_sample());
      if (frame != 0 && cols != 0) counted += n_beats;
      settle();
      settings_used++;
    end

    $display("%0d sample beats sent over %0d length settings, %0d columns compared",
             beats_sent, settings_used, columns_checked);
    if (fail_count == 0) begin
      $display("tb_minmax_decimator_unit OK");
    end else begin
      $display("tb_minmax_decimator_unit NOT OK");
    end
    $finish;
  end

endmodule

### minmax_decimator_unit.f
hdl/mmdec_pkg.sv
hdl/minmax_decimator_unit.sv
verif/minmax_decimator_checker.sv
verif/tb_minmax_decimator_unit.sv
